// ----- hdl/serial_touch_panel_responder_defines.svh -----
// Assertion macros shared by the responder RTL.
`ifndef SERIAL_TOUCH_PANEL_RESPONDER_DEFINES_SVH
`define SERIAL_TOUCH_PANEL_RESPONDER_DEFINES_SVH

// Check that cons holds in the cycle where ante holds.
`define STPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define STPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/stpr_pkg.sv -----
`default_nettype none
package stpr_pkg;

	localparam int unsigned FRAME_BYTES = 10;
	localparam int unsigned READ_LIMIT  = 64;

	localparam logic [7:0] CK_OFFSET = 8'h56;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_P_LO   = 8'h70;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] P_MODEL   = 8'h06;
	localparam logic [7:0] Z_PRESSED = 8'hFF;

	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CMAX = 2'd1;

	localparam logic [7:0]  SYNC_RESET  = 8'd170;
	localparam logic [11:0] CMAX_RESET  = 12'd4095;
	localparam logic [11:0] COORD_RESET = 12'd2047;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  data_byte;
		logic [6:0]  read_cap;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic        touch_down;
	} stpr_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} stpr_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_FETCH,
		S_DRAIN,
		S_TFRAME
	} stpr_state_t;

	function automatic logic [7:0] p_byte(input logic [3:0] idx, input logic [7:0] sync);
		logic [7:0] res;
		case (idx)
			4'd0: res = sync;
			4'd1: res = CH_P;
			4'd2: res = CH_ZERO;
			4'd3: res = P_MODEL;
			4'd9: res = sync + CH_P + CH_ZERO + P_MODEL - CK_OFFSET;
			default: res = 8'h00;
		endcase
		return res;
	endfunction

	function automatic logic [7:0] t_byte(input logic [3:0] idx, input logic [7:0] sync,
			input logic [11:0] wx, input logic [11:0] wy, input logic pressed);
		logic [7:0] z;
		logic [7:0] ck;
		logic [7:0] res;
		z = pressed ? Z_PRESSED : 8'h00;
		ck = sync + CH_T + {7'b0, pressed} + wx[7:0] + {4'b0, wx[11:8]}
			+ wy[7:0] + {4'b0, wy[11:8]} + z - CK_OFFSET;
		case (idx)
			4'd0: res = sync;
			4'd1: res = CH_T;
			4'd2: res = {7'b0, pressed};
			4'd3: res = wx[7:0];
			4'd4: res = {4'b0, wx[11:8]};
			4'd5: res = wy[7:0];
			4'd6: res = {4'b0, wy[11:8]};
			4'd7: res = z;
			4'd9: res = ck;
			default: res = 8'h00;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/stpr_ram.sv -----
`default_nettype none
module stpr_ram #(
	parameter int unsigned WIDTH  = 8,
	parameter int unsigned DEPTH  = 32,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/serial_touch_panel_responder.sv -----
// Emulated serial touch panel. Host byte writes and position samples are taken
// while idle. The tenth byte of a 'p'/'P' frame, when the reply fits, stalls
// requests while the P reply is written into the transmit store, one byte per
// cycle through the store's single write port. A read is accepted, then the
// first queued byte, if any, is fetched, then bytes are delivered one per cycle
// from the store while the output is not stalled, followed by a ten-byte T frame
// when it fits within the read cap. The transmit store needs no clearing pass.
`default_nettype none
`include "serial_touch_panel_responder_defines.svh"
module serial_touch_panel_responder
	import stpr_pkg::*;
#(
	parameter int unsigned TX_BYTES = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire stpr_in_t              req_data,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output stpr_out_t                  rsp_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned LEN_W = $clog2(TX_BYTES + 1);
	localparam int unsigned AW    = $clog2(TX_BYTES);
	localparam int unsigned CW    = (LEN_W > 7) ? LEN_W : 7;

	stpr_state_t state_q, state_d;

	logic [7:0]       sync_q;
	logic [11:0]      cmax_q;
	logic [3:0]       rx_count_q;
	logic [7:0]       rx_cmd_q;
	logic [LEN_W-1:0] tx_length_q;
	logic [LEN_W-1:0] tx_offset_q;
	logic [11:0]      cur_x_q;
	logic [11:0]      cur_y_q;
	logic             pressed_q;
	logic [3:0]       p_idx_q;
	logic [3:0]       t_idx_q;
	logic [6:0]       drain_left_q;
	logic             do_t_q;
	logic             rsp_valid_q;
	stpr_out_t        rsp_data_q;

	logic             out_free;
	logic             out_load;
	stpr_out_t        out_d;
	logic             ram_we;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;
	logic [LEN_W-1:0] push_pos;
	logic [LEN_W-1:0] off_next;
	logic [11:0]      wx;
	logic [11:0]      wy;
	logic [6:0]       cap_c;
	logic [CW-1:0]    avail;
	logic [6:0]       drain_n;
	logic             t_ok;
	logic             frame_done;
	logic             is_p_cmd;
	logic             fits;
	logic             rx_take;
	logic [11:0]      sat_x;
	logic [11:0]      sat_y;

	assign req_stall  = (state_q != S_IDLE);
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign push_pos   = tx_length_q + LEN_W'(p_idx_q);
	assign off_next   = tx_offset_q + LEN_W'(1);
	assign wx         = cmax_q - cur_x_q;
	assign wy         = cmax_q - cur_y_q;
	assign cap_c      = (req_data.read_cap > 7'(READ_LIMIT)) ? 7'(READ_LIMIT)
		: req_data.read_cap;
	assign avail      = CW'(tx_length_q - tx_offset_q);
	assign drain_n    = (avail < CW'(cap_c)) ? avail[6:0] : cap_c;
	assign t_ok       = ({1'b0, drain_n} + 8'(FRAME_BYTES)) <= {1'b0, cap_c};
	assign rx_take    = (rx_count_q != 4'd0) || (req_data.data_byte == sync_q);
	assign frame_done = rx_take && (rx_count_q == 4'(FRAME_BYTES - 1));
	assign is_p_cmd   = (rx_cmd_q == CH_P) || (rx_cmd_q == CH_P_LO);
	assign fits       = ({1'b0, tx_length_q} + (LEN_W+1)'(FRAME_BYTES))
		<= (LEN_W+1)'(TX_BYTES);
	assign sat_x      = (req_data.pos_x > cmax_q) ? cmax_q : req_data.pos_x;
	assign sat_y      = (req_data.pos_y > cmax_q) ? cmax_q : req_data.pos_y;

	stpr_ram #(
		.WIDTH (8),
		.DEPTH (TX_BYTES),
		.ADDR_W(AW)
	) u_tx_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(push_pos[AW-1:0]),
		.wdata(p_byte(p_idx_q, sync_q)),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		out_d     = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = tx_offset_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_data.req_type)
						REQ_WRITE: begin
							if (frame_done && is_p_cmd && fits) begin
								state_d = S_PUSH;
							end
						end
						REQ_READ: begin
							if (drain_n != 7'd0) begin
								state_d = S_FETCH;
							end else if (t_ok) begin
								state_d = S_TFRAME;
							end
						end
						default: ;
					endcase
				end
			end
			S_PUSH: begin
				ram_we = 1'b1;
				if (p_idx_q == 4'(FRAME_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				ram_re  = 1'b1;
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (out_free) begin
					out_load        = 1'b1;
					out_d.out_byte  = ram_rdata;
					out_d.last_byte = (drain_left_q == 7'd1) && !do_t_q;
					if (drain_left_q == 7'd1) begin
						state_d = do_t_q ? S_TFRAME : S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = off_next[AW-1:0];
					end
				end
			end
			S_TFRAME: begin
				if (out_free) begin
					out_load        = 1'b1;
					out_d.out_byte  = t_byte(t_idx_q, sync_q, wx, wy, pressed_q);
					out_d.last_byte = (t_idx_q == 4'(FRAME_BYTES - 1));
					if (t_idx_q == 4'(FRAME_BYTES - 1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q       <= SYNC_RESET;
			cmax_q       <= CMAX_RESET;
			rx_count_q   <= '0;
			rx_cmd_q     <= '0;
			tx_length_q  <= '0;
			tx_offset_q  <= '0;
			cur_x_q      <= COORD_RESET;
			cur_y_q      <= COORD_RESET;
			pressed_q    <= 1'b0;
			p_idx_q      <= '0;
			t_idx_q      <= '0;
			drain_left_q <= '0;
			do_t_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYNC: sync_q <= cfg_data[7:0];
					CFG_CMAX: cmax_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						case (req_data.req_type)
							REQ_WRITE: begin
								p_idx_q <= '0;
								if (rx_take) begin
									if (rx_count_q == 4'd1) begin
										rx_cmd_q <= req_data.data_byte;
									end
									rx_count_q <= frame_done ? 4'd0 : rx_count_q + 4'd1;
								end
							end
							REQ_READ: begin
								drain_left_q <= drain_n;
								do_t_q       <= t_ok;
								t_idx_q      <= '0;
							end
							REQ_SAMPLE: begin
								cur_x_q   <= sat_x;
								cur_y_q   <= sat_y;
								pressed_q <= req_data.touch_down;
							end
							default: ;
						endcase
					end
				end
				S_PUSH: begin
					p_idx_q <= p_idx_q + 4'd1;
					if (p_idx_q == 4'(FRAME_BYTES - 1)) begin
						tx_length_q <= tx_length_q + LEN_W'(FRAME_BYTES);
					end
				end
				S_DRAIN: begin
					if (out_load) begin
						drain_left_q <= drain_left_q - 7'd1;
						if (drain_left_q == 7'd1 && off_next == tx_length_q) begin
							tx_length_q <= '0;
							tx_offset_q <= '0;
						end else begin
							tx_offset_q <= off_next;
						end
					end
				end
				S_TFRAME: begin
					if (out_load) begin
						t_idx_q <= t_idx_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_data_q <= out_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	`STPR_ASSERT_NOW(a_off_in_len, 1'b1, tx_offset_q <= tx_length_q, "offset past length")
	`STPR_ASSERT_NOW(a_len_in_store, 1'b1, tx_length_q <= LEN_W'(TX_BYTES), "length past store")
	`STPR_ASSERT_NEXT(a_push_grows, state_q == S_PUSH && p_idx_q == 4'(FRAME_BYTES - 1), tx_length_q == $past(tx_length_q) + LEN_W'(FRAME_BYTES), "push did not grow queue")
	`STPR_ASSERT_NEXT(a_last_ends_read, out_load && out_d.last_byte, state_q == S_IDLE, "read continued after last byte")

endmodule
`default_nettype wire

// ----- tb/sv/stpr_reply_checker.sv -----
module stpr_reply_checker
	import stpr_pkg::*;
#(
	parameter int unsigned TX_BYTES = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_stall,
	input  stpr_in_t              req_data,
	input  logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  stpr_out_t             rsp_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    replies_due,
	output int                    errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	logic [7:0]  sync_q;
	logic [11:0] cmax_q;
	logic [3:0]  rx_cnt;
	logic [7:0]  rx_cmd;
	logic [7:0]  tx_mem [TX_BYTES];
	int unsigned tx_len;
	int unsigned tx_off;
	logic [11:0] cur_x;
	logic [11:0] cur_y;
	logic        pressed;
	stpr_out_t   panel_bytes_due [$];

	task automatic report_error(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	function automatic frame_t sealed(input frame_t f);
		logic [7:0] s;
		s = 8'h00;
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			s += f[i];
		f[FRAME_BYTES-1] = s - CK_OFFSET;
		return f;
	endfunction

	function automatic frame_t touch_report();
		frame_t f;
		logic [11:0] wx;
		logic [11:0] wy;
		wx = cmax_q - cur_x;
		wy = cmax_q - cur_y;
		f = '0;
		f[0] = sync_q;
		f[1] = CH_T;
		f[2] = {7'b0, pressed};
		f[3] = wx[7:0];
		f[4] = {4'b0, wx[11:8]};
		f[5] = wy[7:0];
		f[6] = {4'b0, wy[11:8]};
		f[7] = pressed ? Z_PRESSED : 8'h00;
		return sealed(f);
	endfunction

	function automatic frame_t probe_reply();
		frame_t f;
		f = '0;
		f[0] = sync_q;
		f[1] = CH_P;
		f[2] = CH_ZERO;
		f[3] = P_MODEL;
		return sealed(f);
	endfunction

	task automatic queue_reply_frame(input frame_t f);
		if (tx_off >= tx_len) begin
			tx_len = 0;
			tx_off = 0;
		end
		// drop a reply that would overflow the store
		if (tx_len + FRAME_BYTES > TX_BYTES)
			return;
		for (int i = 0; i < FRAME_BYTES; i++)
			tx_mem[tx_len + i] = f[i];
		tx_len += FRAME_BYTES;
	endtask

	task automatic take_host_byte(input logic [7:0] b);
		if (rx_cnt == 0 && b != sync_q)
			return;
		if (rx_cnt == 1)
			rx_cmd = b;
		rx_cnt++;
		if (rx_cnt < FRAME_BYTES)
			return;
		if (rx_cmd == CH_P || rx_cmd == CH_P_LO)
			queue_reply_frame(probe_reply());
		rx_cnt = 0;
	endtask

	task automatic serve_host_read(input logic [6:0] cap_in);
		int unsigned cap;
		logic [7:0] run [$];
		frame_t f;
		cap = cap_in;
		if (cap > READ_LIMIT)
			cap = READ_LIMIT;
		while (tx_off < tx_len && run.size() < cap) begin
			run.push_back(tx_mem[tx_off % TX_BYTES]);
			tx_off++;
		end
		if (tx_off >= tx_len) begin
			tx_len = 0;
			tx_off = 0;
		end
		if (run.size() + FRAME_BYTES <= cap) begin
			f = touch_report();
			for (int k = 0; k < FRAME_BYTES; k++)
				run.push_back(f[k]);
		end
		for (int k = 0; k < run.size(); k++)
			panel_bytes_due.push_back('{out_byte: run[k], last_byte: (k == run.size() - 1)});
	endtask

	task automatic latch_sample(input logic [11:0] x, input logic [11:0] y, input logic t);
		cur_x = (x > cmax_q) ? cmax_q : x;
		cur_y = (y > cmax_q) ? cmax_q : y;
		pressed = t;
	endtask

	task automatic check_panel_byte(input stpr_out_t got);
		stpr_out_t want;
		if (panel_bytes_due.size() == 0) begin
			report_error($sformatf("unexpected reply byte %02h last %0b",
				got.out_byte, got.last_byte));
			return;
		end
		want = panel_bytes_due.pop_front();
		if (got.out_byte !== want.out_byte)
			report_error($sformatf("reply byte %02h, expected %02h",
				got.out_byte, want.out_byte));
		if (got.last_byte !== want.last_byte)
			report_error($sformatf("last flag %0b on byte %02h, expected %0b",
				got.last_byte, got.out_byte, want.last_byte));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q = SYNC_RESET;
			cmax_q = CMAX_RESET;
			rx_cnt = '0;
			rx_cmd = '0;
			tx_len = 0;
			tx_off = 0;
			cur_x = COORD_RESET;
			cur_y = COORD_RESET;
			pressed = 1'b0;
			panel_bytes_due.delete();
			errors = 0;
			replies_due <= 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_panel_byte(rsp_data);
			if (req_valid && !req_stall) begin
				case (req_data.req_type)
					REQ_WRITE: take_host_byte(req_data.data_byte);
					REQ_READ: serve_host_read(req_data.read_cap);
					REQ_SAMPLE: latch_sample(req_data.pos_x, req_data.pos_y,
						req_data.touch_down);
					default: ;
				endcase
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYNC: sync_q = cfg_data[7:0];
					CFG_CMAX: cmax_q = cfg_data[11:0];
					default: ;
				endcase
			end
			replies_due <= panel_bytes_due.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
module tb
	import stpr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TX_DEPTH = 32;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned SETTLE = 16;
	localparam int unsigned PHASE_ITEMS = 20;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	stpr_in_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	stpr_out_t rsp_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic calm = 1'b0;
	logic [7:0] sync_now = SYNC_RESET;
	int replies_due;
	int errors;
	int unsigned sent = 0;

	serial_touch_panel_responder #(.TX_BYTES(TX_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	stpr_reply_checker #(.TX_BYTES(TX_DEPTH)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.replies_due(replies_due),
		.errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 32);
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("serial_touch_panel_responder verification failed");
		$finish;
	end

	function automatic stpr_in_t any_request(input logic [1:0] kind);
		stpr_in_t r;
		r.req_type = kind;
		r.data_byte = 8'($urandom_range(255));
		r.read_cap = 7'($urandom_range(127));
		r.pos_x = 12'($urandom_range(4095));
		r.pos_y = 12'($urandom_range(4095));
		r.touch_down = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic logic [6:0] pick_cap();
		logic [6:0] c;
		case ($urandom_range(3))
			0: c = 7'($urandom_range(12));
			1: c = 7'($urandom_range(64));
			2: c = 7'($urandom_range(127, 65));
			default: c = 7'($urandom_range(30, 10));
		endcase
		return c;
	endfunction

	function automatic logic [11:0] pick_coord();
		logic [11:0] c;
		case ($urandom_range(3))
			0: c = 12'd0;
			1: c = 12'd4095;
			default: c = 12'($urandom_range(4095));
		endcase
		return c;
	endfunction

	task automatic send_request(input stpr_in_t r);
		while (!calm && $urandom_range(99) < 32) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (r.req_type != REQ_UNUSED)
			sent++;
	endtask

	task automatic host_byte(input logic [7:0] b);
		stpr_in_t r;
		r = any_request(REQ_WRITE);
		r.data_byte = b;
		send_request(r);
	endtask

	task automatic host_read(input logic [6:0] cap);
		stpr_in_t r;
		r = any_request(REQ_READ);
		r.read_cap = cap;
		send_request(r);
	endtask

	task automatic pos_sample(input logic [11:0] x, input logic [11:0] y, input logic t);
		stpr_in_t r;
		r = any_request(REQ_SAMPLE);
		r.pos_x = x;
		r.pos_y = y;
		r.touch_down = t;
		send_request(r);
	endtask

	task automatic send_frame(input logic [7:0] cmd);
		host_byte(sync_now);
		host_byte(cmd);
		repeat (FRAME_BYTES - 2)
			host_byte(8'($urandom_range(255)));
	endtask

	// overfill the transmit store, then drain it
	task automatic flood_store();
		repeat (4)
			send_frame($urandom_range(1) ? CH_P : CH_P_LO);
		host_read(7'd64);
		host_read(7'd64);
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic write_settings(input logic [7:0] s, input logic [11:0] m, input bit spare);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SYNC;
		cfg_data <= {4'($urandom_range(15)), s};
		@(posedge clk);
		cfg_index <= CFG_CMAX;
		cfg_data <= m;
		@(posedge clk);
		if (spare) begin
			cfg_index <= CFG_SPARE_A;
			cfg_data <= 12'($urandom_range(4095));
			@(posedge clk);
			cfg_index <= CFG_SPARE_B;
			cfg_data <= 12'($urandom_range(4095));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		sync_now = s;
	endtask

	task automatic random_phase(input int unsigned budget);
		int unsigned stop;
		stop = sent + budget;
		host_read(7'($urandom_range(64, 10)));
		while (sent < stop) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					if ($urandom_range(3) == 0)
						send_frame(8'($urandom_range(255)));
					else
						send_frame($urandom_range(1) ? CH_P : CH_P_LO);
				end
				3: begin
					repeat ($urandom_range(3, 1))
						host_byte(($urandom_range(7) == 0) ? sync_now : 8'($urandom_range(255)));
				end
				4, 5: host_read(pick_cap());
				6: pos_sample(pick_coord(), pick_coord(), 1'($urandom_range(1)));
				7: begin
					// broken frame: the next bytes complete it
					host_byte(sync_now);
					host_byte(CH_P);
					repeat ($urandom_range(6))
						host_byte(8'($urandom_range(255)));
				end
				8: send_request(any_request(REQ_UNUSED));
				default: begin
					send_frame(CH_P);
					host_read(7'($urandom_range(9, 1)));
				end
			endcase
		end
	endtask

	task automatic run_phase(input logic [7:0] s, input logic [11:0] m, input bit spare,
			input bit no_idle);
		wait_quiet();
		write_settings(s, m, spare);
		calm <= no_idle;
		random_phase(PHASE_ITEMS);
	endtask

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		host_read(7'd0);
		host_read(7'd9);
		host_read(7'd10);
		send_request(any_request(REQ_UNUSED));
		pos_sample(12'd4095, 12'd0, 1'b1);
		host_read(7'd127);
		host_byte(8'h00);
		host_byte(sync_now);
		host_byte(CH_P_LO);
		host_byte(8'h00);
		host_byte(8'hFF);
		repeat (FRAME_BYTES - 4)
			host_byte(8'($urandom_range(255)));
		host_read(7'd3);
		pos_sample(12'd0, 12'd4095, 1'b0);
		host_read(7'd64);
		host_read(7'd65);

		run_phase(8'hFF, 12'd4095, 1'b0, 1'b0);
		flood_store();
		run_phase(8'h00, 12'd1, 1'b1, 1'b0);
		run_phase(8'($urandom_range(255)), 12'($urandom_range(4095, 1)), 1'b0, 1'b1);
		run_phase(8'h55, 12'd0, 1'b1, 1'b0);
		run_phase(CH_P, 12'($urandom_range(4095, 1)), 1'b0, 1'b0);
		flood_store();
		run_phase(8'($urandom_range(255)), 12'($urandom_range(4095)), 1'b1, 1'b0);
		run_phase(8'($urandom_range(255)), 12'd4095, 1'b0, 1'b0);
		run_phase(SYNC_RESET, CMAX_RESET, 1'b0, 1'b0);
		wait_quiet();

		if (errors == 0 && replies_due == 0)
			$display("serial_touch_panel_responder verification clean");
		else
			$display("serial_touch_panel_responder verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/stpr_pkg.sv
hdl/stpr_ram.sv
hdl/serial_touch_panel_responder.sv
tb/sv/stpr_reply_checker.sv
tb/sv/tb.sv
